// ----- src/tgfw_pkg.sv -----
// Shared types, codes and font table for the text glyph frame buffer writer.
package tgfw_pkg;

    // Command codes of the command word
    typedef enum logic [2:0] {
        CMD_CLEAR     = 3'd0,
        CMD_SET_CUR   = 3'd1,
        CMD_WRITE     = 3'd2,
        CMD_WRITE_INV = 3'd3,
        CMD_FILL      = 3'd4,
        CMD_READ      = 3'd5
    } t_cmd;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GLYPH,
        ST_FILL,
        ST_READ,
        ST_RESULT
    } t_state;

    // Widest frame store address over the supported geometry (16 pages of 256)
    localparam int MAX_AW = 12;

    // Configuration port
    localparam int   PADDR_W           = 3;
    localparam logic REG_DISPLAY_READY = 1'b0;

    // Glyph constants
    localparam logic [7:0] FIRST_CODE  = 8'h20;
    localparam logic [7:0] LAST_CODE   = 8'h7E;
    localparam logic [7:0] SUBST_CODE  = 8'h3F;
    localparam int         GLYPH_PITCH = 6;
    localparam logic [7:0] INV_MASK    = 8'hFF;
    localparam logic [7:0] BLANK_BYTE  = 8'h00;

    // One frame store access: write or read at one address
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [MAX_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

    // 5x7 font, five column bytes per glyph, first column in the top byte
    function automatic logic [39:0] glyph_bits(input logic [6:0] idx);
        logic [39:0] bits;
        case (idx)
            7'd0:  bits = 40'h0000000000;  7'd1:  bits = 40'h00005F0000;
            7'd2:  bits = 40'h0007000700;  7'd3:  bits = 40'h147F147F14;
            7'd4:  bits = 40'h242A7F2A12;  7'd5:  bits = 40'h2313086462;
            7'd6:  bits = 40'h3649552250;  7'd7:  bits = 40'h0005030000;
            7'd8:  bits = 40'h001C224100;  7'd9:  bits = 40'h0041221C00;
            7'd10: bits = 40'h14083E0814;  7'd11: bits = 40'h08083E0808;
            7'd12: bits = 40'h0050300000;  7'd13: bits = 40'h0808080808;
            7'd14: bits = 40'h0060600000;  7'd15: bits = 40'h2010080402;
            7'd16: bits = 40'h3E5149453E;  7'd17: bits = 40'h00427F4000;
            7'd18: bits = 40'h4261514946;  7'd19: bits = 40'h2141454B31;
            7'd20: bits = 40'h1814127F10;  7'd21: bits = 40'h2745454539;
            7'd22: bits = 40'h3C4A494930;  7'd23: bits = 40'h0171090503;
            7'd24: bits = 40'h3649494936;  7'd25: bits = 40'h064949291E;
            7'd26: bits = 40'h0036360000;  7'd27: bits = 40'h0056360000;
            7'd28: bits = 40'h0814224100;  7'd29: bits = 40'h1414141414;
            7'd30: bits = 40'h0041221408;  7'd31: bits = 40'h0201510906;
            7'd32: bits = 40'h324979413E;  7'd33: bits = 40'h7E1111117E;
            7'd34: bits = 40'h7F49494936;  7'd35: bits = 40'h3E41414122;
            7'd36: bits = 40'h7F4141221C;  7'd37: bits = 40'h7F49494941;
            7'd38: bits = 40'h7F09090901;  7'd39: bits = 40'h3E4149497A;
            7'd40: bits = 40'h7F0808087F;  7'd41: bits = 40'h00417F4100;
            7'd42: bits = 40'h2040413F01;  7'd43: bits = 40'h7F08142241;
            7'd44: bits = 40'h7F40404040;  7'd45: bits = 40'h7F020C027F;
            7'd46: bits = 40'h7F0408107F;  7'd47: bits = 40'h3E4141413E;
            7'd48: bits = 40'h7F09090906;  7'd49: bits = 40'h3E4151215E;
            7'd50: bits = 40'h7F09192946;  7'd51: bits = 40'h4649494931;
            7'd52: bits = 40'h01017F0101;  7'd53: bits = 40'h3F4040403F;
            7'd54: bits = 40'h1F2040201F;  7'd55: bits = 40'h3F4038403F;
            7'd56: bits = 40'h6314081463;  7'd57: bits = 40'h0708700807;
            7'd58: bits = 40'h6151494543;  7'd59: bits = 40'h007F414100;
            7'd60: bits = 40'h0204081020;  7'd61: bits = 40'h0041417F00;
            7'd62: bits = 40'h0402010204;  7'd63: bits = 40'h4040404040;
            7'd64: bits = 40'h0001020400;  7'd65: bits = 40'h2054545478;
            7'd66: bits = 40'h7F48444438;  7'd67: bits = 40'h3844444420;
            7'd68: bits = 40'h384444487F;  7'd69: bits = 40'h3854545418;
            7'd70: bits = 40'h087E090102;  7'd71: bits = 40'h0C5252523E;
            7'd72: bits = 40'h7F08040478;  7'd73: bits = 40'h00447D4000;
            7'd74: bits = 40'h2040443D00;  7'd75: bits = 40'h7F10284400;
            7'd76: bits = 40'h00417F4000;  7'd77: bits = 40'h7C04180478;
            7'd78: bits = 40'h7C08040478;  7'd79: bits = 40'h3844444438;
            7'd80: bits = 40'h7C14141408;  7'd81: bits = 40'h081414187C;
            7'd82: bits = 40'h7C08040408;  7'd83: bits = 40'h4854545420;
            7'd84: bits = 40'h043F444020;  7'd85: bits = 40'h3C4040407C;
            7'd86: bits = 40'h1C2040201C;  7'd87: bits = 40'h3C4030403C;
            7'd88: bits = 40'h4428102844;  7'd89: bits = 40'h0C5050503C;
            7'd90: bits = 40'h4464544C44;  7'd91: bits = 40'h0008364100;
            7'd92: bits = 40'h00007F0000;  7'd93: bits = 40'h0041360800;
            7'd94: bits = 40'h1008081008;
            default: bits = 40'h0000000000;
        endcase
        return bits;
    endfunction

endpackage

// ----- src/tgfw_cmd_if.sv -----
// Command channel: valid/ready handshake carrying one command word.
interface tgfw_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] column;
    logic [7:0] page;
    logic [7:0] char_code;
    logic [7:0] fill_value;

    modport source (output valid, command, column, page, char_code, fill_value,
                    input ready);
    modport sink   (input valid, command, column, page, char_code, fill_value,
                    output ready);
endinterface

// ----- src/tgfw_rsp_if.sv -----
// Result channel: valid/ready handshake carrying one result word.
interface tgfw_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       accepted;
    logic [6:0] cursor_col_out;
    logic [2:0] cursor_page_out;

    modport source (output valid, read_data, accepted, cursor_col_out, cursor_page_out,
                    input ready);
    modport sink   (input valid, read_data, accepted, cursor_col_out, cursor_page_out,
                    output ready);
endinterface

// ----- src/text_glyph_framebuffer_writer.sv -----
// Top level of the text glyph frame buffer writer.
//
// A page-organised monochrome frame store (PAGES pages of COLUMNS bytes) with
// a text cursor. Command words come in on i_cmd (valid/ready); every accepted
// word gives exactly one result word on o_rsp (valid/ready). The APB port
// holds display_ready at byte address 0; pready is always high.
//
// Store work per word, accept to result loaded into the output register:
//   set cursor, skipped or unused commands: no store access
//   read byte: one registered store read
//   write char: six column bytes, one store write per cycle
//   fill row: COLUMNS bytes, clear: PAGES*COLUMNS bytes (one byte per cycle)
// The single store port sets this pace. A new word is accepted in the
// cycle its predecessor's result is loaded, so glyphs can be drawn back
// to back.
// After reset the block sweeps zeros through all PAGES*COLUMNS bytes before
// it accepts a command; configuration writes are taken during that sweep. If
// the receiver stalls, the result waits in the output register while the
// next word is still taken and worked on; its own result then waits until
// the register frees up.
module text_glyph_framebuffer_writer #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tgfw_cmd_if.sink                     i_cmd,
    tgfw_rsp_if.source                   o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tgfw_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);

    logic               display_ready;
    tgfw_pkg::t_mem_req mem_req;
    logic [7:0]         mem_rdata;

    // configuration register
    tgfw_apb u_apb (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_display_ready (display_ready)
    );

    // command sequencer
    tgfw_ctrl #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_display_ready (display_ready),
        .i_cmd           (i_cmd),
        .o_rsp           (o_rsp),
        .o_mem_req       (mem_req),
        .i_mem_rdata     (mem_rdata)
    );

    // frame store
    tgfw_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

// ----- src/tgfw_apb.sv -----
// APB register slave holding the display_ready flag.
module tgfw_apb (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tgfw_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic                         o_display_ready
);

    logic r_display_ready;
    logic sel_ready_reg;

    // register index is the word address
    assign sel_ready_reg = (paddr[2] == tgfw_pkg::REG_DISPLAY_READY);

    // write in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_ready <= 1'b0;
        end else if (psel && penable && pwrite && sel_ready_reg) begin
            r_display_ready <= pwdata[0];
        end
    end

    // read back
    assign prdata          = sel_ready_reg ? {31'd0, r_display_ready} : 32'd0;
    assign pready          = 1'b1;
    assign o_display_ready = r_display_ready;

endmodule

// ----- src/tgfw_store.sv -----
// Frame store: single-port synchronous byte memory with a registered read.
module tgfw_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic               i_clk,
    input  tgfw_pkg::t_mem_req i_req,
    output logic [7:0]         o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
    end

    // registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= mem[i_req.addr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tgfw_ctrl.sv -----
// Command sequencer: cursor, store sweeps, glyph drawing and result register.
module tgfw_ctrl #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_display_ready,
    tgfw_cmd_if.sink           i_cmd,
    tgfw_rsp_if.source         o_rsp,
    output tgfw_pkg::t_mem_req o_mem_req,
    input  logic [7:0]         i_mem_rdata
);

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int RW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int MAW   = tgfw_pkg::MAX_AW;

    tgfw_pkg::t_state r_state, n_state;
    tgfw_pkg::t_cmd   cmd;

    logic [AW-1:0] r_cnt;
    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_boot;
    logic [6:0]    r_glyph;
    logic          r_invert;
    logic [7:0]    r_fill;
    logic          r_res_ok;
    logic          r_res_rd;

    logic          r_out_valid;
    logic [7:0]    r_out_data;
    logic          r_out_ok;
    logic [6:0]    r_out_col;
    logic [2:0]    r_out_row;

    logic          accept;
    logic          out_free;
    logic          out_load;
    logic          col_ok;
    logic          page_ok;
    logic          glyph_go;
    logic          printable;
    logic [6:0]    glyph_idx;
    logic          last_clear;
    logic          last_fill;
    logic          last_glyph;
    logic          sweeping;
    logic [AW-1:0] base_cur;
    logic [AW-1:0] base_in;
    logic [AW-1:0] mem_addr;
    logic [39:0]   font;
    logic [7:0]    glyph_byte;
    logic [CW+6:0] col_ext;
    logic [RW+2:0] row_ext;

    // handshake
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_cmd.ready = (r_state == tgfw_pkg::ST_IDLE) ||
                         ((r_state == tgfw_pkg::ST_RESULT) && out_free);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign cmd         = tgfw_pkg::t_cmd'(i_cmd.command);

    // range checks and addresses of the incoming word
    assign col_ok   = {1'b0, i_cmd.column} < 9'(COLUMNS);
    assign page_ok  = {1'b0, i_cmd.page} < 9'(PAGES);
    assign glyph_go = i_display_ready &&
                      (({1'b0, r_col} + (CW+1)'(tgfw_pkg::GLYPH_PITCH)) <= (CW+1)'(COLUMNS));
    assign base_cur = AW'(r_row * COLUMNS) + AW'(r_col);
    assign base_in  = AW'(RW'(i_cmd.page) * COLUMNS);

    // unprintable codes draw as the substitute glyph
    assign printable = (i_cmd.char_code >= tgfw_pkg::FIRST_CODE) &&
                       (i_cmd.char_code <= tgfw_pkg::LAST_CODE);
    assign glyph_idx = printable ? 7'(i_cmd.char_code - tgfw_pkg::FIRST_CODE)
                                 : 7'(tgfw_pkg::SUBST_CODE - tgfw_pkg::FIRST_CODE);

    // sweep ends
    assign last_clear = (r_cnt == AW'(DEPTH - 1));
    assign last_fill  = (r_cnt == AW'(COLUMNS - 1));
    assign last_glyph = (r_cnt == AW'(tgfw_pkg::GLYPH_PITCH - 1));
    assign sweeping   = r_state inside {tgfw_pkg::ST_CLEAR, tgfw_pkg::ST_GLYPH,
                                        tgfw_pkg::ST_FILL};
    assign mem_addr   = r_addr + r_cnt;

    // current glyph column, gap column last
    assign font = tgfw_pkg::glyph_bits(r_glyph);
    always_comb begin
        case (r_cnt[2:0])
            3'd0:    glyph_byte = font[39:32];
            3'd1:    glyph_byte = font[31:24];
            3'd2:    glyph_byte = font[23:16];
            3'd3:    glyph_byte = font[15:8];
            3'd4:    glyph_byte = font[7:0];
            default: glyph_byte = tgfw_pkg::BLANK_BYTE;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tgfw_pkg::ST_CLEAR: begin
                if (last_clear) begin
                    n_state = r_boot ? tgfw_pkg::ST_IDLE : tgfw_pkg::ST_RESULT;
                end
            end
            tgfw_pkg::ST_IDLE, tgfw_pkg::ST_RESULT: begin
                if (r_state == tgfw_pkg::ST_RESULT && out_free) begin
                    n_state = tgfw_pkg::ST_IDLE;
                end
                if (accept) begin
                    case (cmd)
                        tgfw_pkg::CMD_CLEAR: n_state = tgfw_pkg::ST_CLEAR;
                        tgfw_pkg::CMD_WRITE, tgfw_pkg::CMD_WRITE_INV: begin
                            n_state = glyph_go ? tgfw_pkg::ST_GLYPH : tgfw_pkg::ST_RESULT;
                        end
                        tgfw_pkg::CMD_FILL: begin
                            n_state = page_ok ? tgfw_pkg::ST_FILL : tgfw_pkg::ST_RESULT;
                        end
                        tgfw_pkg::CMD_READ: begin
                            n_state = (col_ok && page_ok) ? tgfw_pkg::ST_READ
                                                          : tgfw_pkg::ST_RESULT;
                        end
                        default: n_state = tgfw_pkg::ST_RESULT;
                    endcase
                end
            end
            tgfw_pkg::ST_GLYPH: begin
                if (last_glyph) begin
                    n_state = tgfw_pkg::ST_RESULT;
                end
            end
            tgfw_pkg::ST_FILL: begin
                if (last_fill) begin
                    n_state = tgfw_pkg::ST_RESULT;
                end
            end
            tgfw_pkg::ST_READ: n_state = tgfw_pkg::ST_RESULT;
            default:           n_state = tgfw_pkg::ST_IDLE;
        endcase
    end

    // store access and result load
    always_comb begin
        o_mem_req.wr_en = sweeping;
        o_mem_req.rd_en = (r_state == tgfw_pkg::ST_READ);
        o_mem_req.addr  = MAW'(mem_addr);
        case (r_state)
            tgfw_pkg::ST_FILL:  o_mem_req.wdata = r_fill;
            tgfw_pkg::ST_GLYPH: o_mem_req.wdata = glyph_byte ^ {8{r_invert}};
            default:            o_mem_req.wdata = tgfw_pkg::BLANK_BYTE;
        endcase
        out_load = (r_state == tgfw_pkg::ST_RESULT) && out_free;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tgfw_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // sweep counter and boot flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_boot <= 1'b1;
        end else begin
            if (accept) begin
                r_cnt <= '0;
            end else if (sweeping) begin
                if ((r_state == tgfw_pkg::ST_CLEAR && last_clear) ||
                    (r_state == tgfw_pkg::ST_FILL && last_fill) ||
                    (r_state == tgfw_pkg::ST_GLYPH && last_glyph)) begin
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (r_state == tgfw_pkg::ST_CLEAR && last_clear) begin
                r_boot <= 1'b0;
            end
        end
    end

    // cursor and sweep base address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_addr <= '0;
        end else if (accept) begin
            case (cmd)
                tgfw_pkg::CMD_CLEAR: begin
                    r_col  <= '0;
                    r_row  <= '0;
                    r_addr <= '0;
                end
                tgfw_pkg::CMD_SET_CUR: begin
                    r_col <= col_ok ? CW'(i_cmd.column) : '0;
                    r_row <= page_ok ? RW'(i_cmd.page) : '0;
                end
                tgfw_pkg::CMD_WRITE, tgfw_pkg::CMD_WRITE_INV: begin
                    r_addr <= base_cur;
                    if (glyph_go) begin
                        r_col <= r_col + CW'(tgfw_pkg::GLYPH_PITCH);
                    end
                end
                tgfw_pkg::CMD_FILL: r_addr <= base_in;
                tgfw_pkg::CMD_READ: r_addr <= base_in + AW'(i_cmd.column);
                default: ;
            endcase
        end
    end

    // command word operands and pending result flags
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_glyph  <= glyph_idx;
            r_invert <= (cmd == tgfw_pkg::CMD_WRITE_INV);
            r_fill   <= i_cmd.fill_value;
            r_res_rd <= 1'b0;
            case (cmd)
                tgfw_pkg::CMD_CLEAR, tgfw_pkg::CMD_SET_CUR: r_res_ok <= 1'b1;
                tgfw_pkg::CMD_WRITE, tgfw_pkg::CMD_WRITE_INV: r_res_ok <= glyph_go;
                tgfw_pkg::CMD_FILL: r_res_ok <= page_ok;
                tgfw_pkg::CMD_READ: begin
                    r_res_ok <= col_ok && page_ok;
                    r_res_rd <= col_ok && page_ok;
                end
                default: r_res_ok <= 1'b0;
            endcase
        end
    end

    // output register
    assign col_ext = {7'd0, r_col};
    assign row_ext = {3'd0, r_row};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= r_res_rd ? i_mem_rdata : 8'd0;
            r_out_ok   <= r_res_ok;
            r_out_col  <= col_ext[6:0];
            r_out_row  <= row_ext[2:0];
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.read_data       = r_out_data;
    assign o_rsp.accepted        = r_out_ok;
    assign o_rsp.cursor_col_out  = r_out_col;
    assign o_rsp.cursor_page_out = r_out_row;

`ifndef NO_ASSERTIONS
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW+1)'(r_col) <= (CW+1)'(COLUMNS))
        else $error("cursor column beyond the page width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (RW+1)'(r_row) < (RW+1)'(PAGES))
        else $error("cursor page beyond the store");

    a_wr_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.wr_en |-> ((MAW+1)'(o_mem_req.addr) < (MAW+1)'(DEPTH)))
        else $error("store write outside the frame");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.rd_en |=> (r_state == tgfw_pkg::ST_RESULT))
        else $error("read data not taken into the result");

    a_glyph_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && glyph_go &&
         (cmd == tgfw_pkg::CMD_WRITE || cmd == tgfw_pkg::CMD_WRITE_INV))
        |=> (r_state == tgfw_pkg::ST_GLYPH) && (r_cnt == '0))
        else $error("glyph draw did not start at its first column");
`endif

endmodule
